@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, ignored while rst_n is low.
`define SFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants for the sync/length framed byte parser.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned EventW   = 2;
    localparam int unsigned CfgIdxW  = 8;

    localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
    localparam logic [ByteW-1:0] SyncSecondRst = 8'h55;
    localparam logic [ByteW-1:0] HdrTrlBytes   = 8'd5;

    // register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 8'd1;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_TAG   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef enum logic [EventW-1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_GOOD    = 2'd2,
        EV_ERROR   = 2'd3
    } event_t;

endpackage

@@ src/sfd_if.sv @@
// ----------------------------------------------------------------------------
// sfd_if
// Request channels of the framed byte parser: byte in, result out, config.
// ----------------------------------------------------------------------------
interface sfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::ByteW-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::EventW-1:0]  event_res;
    logic [sfd_pkg::ByteW-1:0]   payload_byte;
    logic [sfd_pkg::ByteW-1:0]   payload_index;
    logic [sfd_pkg::ByteW-1:0]   frame_tag;
    logic [sfd_pkg::ByteW-1:0]   payload_length;
    logic [sfd_pkg::ByteW-1:0]   sum_seen;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output frame_tag, output payload_length,
                    output sum_seen, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input frame_tag, input payload_length,
                    input sum_seen, output ready);
endinterface

interface sfd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::CfgIdxW-1:0] index;
    logic [sfd_pkg::ByteW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/sync_frame_deframer_sum8.sv @@
// ----------------------------------------------------------------------------
// sync_frame_deframer_sum8
// Byte-serial parser for sync1, sync2, length, id, payload, checksum frames.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per request (valid/ready).
//   res : one result per accepted byte: event code (none, payload byte,
//         frame good, checksum error), payload byte and its index, frame id,
//         payload length and the running 8-bit sum.
//   cfg : writes sync_first (index 0) and sync_second (index 1); other
//         indexes are dropped. Always ready; write only while idle.
// Result: a byte accepted at a clock edge has its result loaded into the
//   result register at that same edge.
// Throughput: one byte per cycle while results are taken, set by the single
//   parse step between the input handshake and the result register.
// Stall: rx.ready stays high while the result register is empty or is being
//   taken this cycle; when the receiver holds res.ready low with a result
//   pending, rx.ready drops and the result holds.
// Reset: parser hunts for sync_first, sum/count/length/id cleared, sync bytes
//   back to 0xAA / 0x55, result register empty.
// ----------------------------------------------------------------------------
module sync_frame_deframer_sum8 (
    input  logic      clk,
    input  logic      rst_n,
    sfd_in_if.sink    rx,
    sfd_out_if.source res,
    sfd_cfg_if.sink   cfg
);

    localparam int unsigned W = sfd_pkg::ByteW;

    // configuration
    logic [W-1:0] sync_first_reg;
    logic [W-1:0] sync_second_reg;

    // parser state
    sfd_pkg::phase_t phase_reg, phase_next;
    logic [W-1:0]    sum_reg, sum_next;
    logic [W-1:0]    count_reg, count_next;
    logic [W-1:0]    expect_reg, expect_next;
    logic [W-1:0]    tag_reg, tag_next;

    // result register
    logic                          out_valid_reg;
    sfd_pkg::event_t               ev_reg, ev_next;
    logic [W-1:0]                  pbyte_reg, pbyte_next;
    logic [W-1:0]                  pidx_reg, pidx_next;
    logic [W-1:0]                  tag_out_reg, tag_out_next;
    logic [W-1:0]                  len_out_reg, len_out_next;
    logic [W-1:0]                  sum_out_reg, sum_out_next;

    logic         in_fire;
    logic [W-1:0] b;
    logic [W-1:0] count_inc;
    logic         done;

    assign rx.ready  = !out_valid_reg || res.ready;
    assign in_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;
    assign b         = rx.rx_byte;
    assign count_inc = count_reg + W'(1);

    // one parse step per accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        expect_next = expect_reg;
        tag_next    = tag_reg;
        ev_next     = sfd_pkg::EV_NONE;
        pbyte_next  = '0;
        pidx_next   = '0;
        done        = 1'b0;

        unique case (phase_reg)
            sfd_pkg::PH_SYNC1:
            begin
                if (b == sync_first_reg)
                begin
                    phase_next = sfd_pkg::PH_SYNC2;
                    sum_next   = b;
                end
            end
            sfd_pkg::PH_SYNC2:
            begin
                if (b == sync_second_reg)
                begin
                    phase_next = sfd_pkg::PH_LEN;
                    sum_next   = sum_reg + b;
                end
                else
                begin
                    // mismatch: back to hunting, byte not retried as sync1
                    phase_next  = sfd_pkg::PH_SYNC1;
                    sum_next    = '0;
                    count_next  = '0;
                    expect_next = '0;
                    tag_next    = '0;
                end
            end
            sfd_pkg::PH_LEN:
            begin
                sum_next    = sum_reg + b;
                expect_next = b - sfd_pkg::HdrTrlBytes;   // wraps mod 256
                phase_next  = sfd_pkg::PH_TAG;
            end
            sfd_pkg::PH_TAG:
            begin
                tag_next   = b;
                sum_next   = sum_reg + b;
                phase_next = (expect_reg != '0) ? sfd_pkg::PH_DATA : sfd_pkg::PH_CHECK;
            end
            sfd_pkg::PH_DATA:
            begin
                ev_next    = sfd_pkg::EV_PAYLOAD;
                pbyte_next = b;
                pidx_next  = count_reg;
                count_next = count_inc;
                sum_next   = sum_reg + b;
                if (count_inc >= expect_reg)
                    phase_next = sfd_pkg::PH_CHECK;
            end
            sfd_pkg::PH_CHECK:
            begin
                ev_next = (sum_reg == b) ? sfd_pkg::EV_GOOD : sfd_pkg::EV_ERROR;
                done    = 1'b1;
            end
            default:
            begin
                phase_next  = sfd_pkg::PH_SYNC1;
                sum_next    = '0;
                count_next  = '0;
                expect_next = '0;
                tag_next    = '0;
            end
        endcase

        // reported values are taken before the end-of-frame clear
        tag_out_next = tag_next;
        len_out_next = expect_next;
        sum_out_next = sum_next;

        if (done)
        begin
            phase_next  = sfd_pkg::PH_SYNC1;
            sum_next    = '0;
            count_next  = '0;
            expect_next = '0;
            tag_next    = '0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= sfd_pkg::SyncFirstRst;
            sync_second_reg <= sfd_pkg::SyncSecondRst;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == sfd_pkg::REG_SYNC_FIRST)
                sync_first_reg <= cfg.data;
            else if (cfg.index == sfd_pkg::REG_SYNC_SECOND)
                sync_second_reg <= cfg.data;
        end
    end

    // parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sfd_pkg::PH_SYNC1;
            sum_reg       <= '0;
            count_reg     <= '0;
            expect_reg    <= '0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                sum_reg    <= sum_next;
                count_reg  <= count_next;
                expect_reg <= expect_next;
                tag_reg    <= tag_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ev_reg      <= ev_next;
            pbyte_reg   <= pbyte_next;
            pidx_reg    <= pidx_next;
            tag_out_reg <= tag_out_next;
            len_out_reg <= len_out_next;
            sum_out_reg <= sum_out_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.event_res      = ev_reg;
    assign res.payload_byte   = pbyte_reg;
    assign res.payload_index  = pidx_reg;
    assign res.frame_tag      = tag_out_reg;
    assign res.payload_length = len_out_reg;
    assign res.sum_seen       = sum_out_reg;

endmodule

@@ src/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the framed byte parser, bound into the parser module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sfd_pkg::EventW-1:0]  event_res,
    input logic [sfd_pkg::ByteW-1:0]   payload_byte,
    input logic [sfd_pkg::ByteW-1:0]   payload_index,
    input logic [sfd_pkg::ByteW-1:0]   payload_length
);

    logic is_payload;
    assign is_payload = (event_res == sfd_pkg::EV_PAYLOAD);

    // pending result is not dropped while stalled
    `SFD_ASSERT(a_hold, out_valid && !out_ready |=> out_valid, "result dropped under stall")

    // every accepted byte yields a result on the next cycle
    `SFD_ASSERT(a_latency, in_valid && in_ready |=> out_valid, "missing result after byte")

    // payload index always inside the announced length
    `SFD_ASSERT(a_index, out_valid && is_payload |-> payload_index < payload_length,
                "payload index beyond length")

    // non-payload events carry zero payload fields
    `SFD_ASSERT(a_zero, out_valid && !is_payload |-> payload_byte == '0 && payload_index == '0,
                "payload fields set outside payload event")

endmodule

bind sync_frame_deframer_sum8 sfd_checker u_sfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rx.valid),
    .in_ready       (rx.ready),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .event_res      (res.event_res),
    .payload_byte   (res.payload_byte),
    .payload_index  (res.payload_index),
    .payload_length (res.payload_length)
);

@@ bench/sfd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfd_scoreboard
// Watches the byte, result and register channels of the framed byte parser,
// tracks the parse state and compares every result in order.
// ----------------------------------------------------------------------------
module sfd_scoreboard (
    input  logic clk,
    input  logic rst_n,
    sfd_in_if    rx,
    sfd_out_if   res,
    sfd_cfg_if   cfg,
    output int   errors,
    output int   pending
);

    localparam int ReportMax = 10;
    localparam int ByteW     = sfd_pkg::ByteW;

    typedef struct packed {
        sfd_pkg::event_t  ev;
        logic [ByteW-1:0] pbyte;
        logic [ByteW-1:0] pidx;
        logic [ByteW-1:0] tag;
        logic [ByteW-1:0] plen;
        logic [ByteW-1:0] sum;
    } parse_result_t;

    // register copies
    logic [ByteW-1:0] sync_a;
    logic [ByteW-1:0] sync_b;

    // parse state
    sfd_pkg::phase_t  phase;
    logic [ByteW-1:0] run_sum;
    logic [ByteW-1:0] pay_cnt;
    logic [ByteW-1:0] pay_len;
    logic [ByteW-1:0] cur_tag;

    parse_result_t    due_results[$];
    int               fail_cnt;

    function automatic void clear_frame();
        phase   = sfd_pkg::PH_SYNC1;
        run_sum = '0;
        pay_cnt = '0;
        pay_len = '0;
        cur_tag = '0;
    endfunction

    // advance the parse state by one byte and return the result it gives
    function automatic parse_result_t parse_byte(input logic [ByteW-1:0] b);
        parse_result_t r;
        bit            done;
        r    = '0;
        r.ev = sfd_pkg::EV_NONE;
        done = 1'b0;
        case (phase)
            sfd_pkg::PH_SYNC1:
            begin
                if (b == sync_a)
                begin
                    phase   = sfd_pkg::PH_SYNC2;
                    run_sum = b;
                end
            end
            sfd_pkg::PH_SYNC2:
            begin
                if (b == sync_b)
                begin
                    phase   = sfd_pkg::PH_LEN;
                    run_sum = run_sum + b;
                end
                else
                begin
                    clear_frame();
                end
            end
            sfd_pkg::PH_LEN:
            begin
                run_sum = run_sum + b;
                pay_len = b - sfd_pkg::HdrTrlBytes;
                phase   = sfd_pkg::PH_TAG;
            end
            sfd_pkg::PH_TAG:
            begin
                cur_tag = b;
                run_sum = run_sum + b;
                phase   = (pay_len != '0) ? sfd_pkg::PH_DATA : sfd_pkg::PH_CHECK;
            end
            sfd_pkg::PH_DATA:
            begin
                r.ev    = sfd_pkg::EV_PAYLOAD;
                r.pbyte = b;
                r.pidx  = pay_cnt;
                pay_cnt = pay_cnt + 1'b1;
                run_sum = run_sum + b;
                if (pay_cnt >= pay_len)
                    phase = sfd_pkg::PH_CHECK;
            end
            sfd_pkg::PH_CHECK:
            begin
                r.ev = (run_sum == b) ? sfd_pkg::EV_GOOD : sfd_pkg::EV_ERROR;
                done = 1'b1;
            end
            default:
            begin
                clear_frame();
            end
        endcase
        r.tag  = cur_tag;
        r.plen = pay_len;
        r.sum  = run_sum;
        if (done)
            clear_frame();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t got;
        parse_result_t want;
        if (!rst_n)
        begin
            sync_a = sfd_pkg::SyncFirstRst;
            sync_b = sfd_pkg::SyncSecondRst;
            clear_frame();
            due_results.delete();
            fail_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // results first: anything taken now was predicted on an earlier edge
            if (res.valid && res.ready)
            begin
                got.ev    = sfd_pkg::event_t'(res.event_res);
                got.pbyte = res.payload_byte;
                got.pidx  = res.payload_index;
                got.tag   = res.frame_tag;
                got.plen  = res.payload_length;
                got.sum   = res.sum_seen;
                if (due_results.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= ReportMax)
                        $display("[%0t] result with none outstanding: ev %0d", $realtime,
                                 got.ev);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= ReportMax)
                        begin
                            $display("[%0t] result mismatch (exp/got): ev %0d/%0d byte %h/%h",
                                     $realtime, want.ev, got.ev, want.pbyte, got.pbyte);
                            $display("    idx %0d/%0d id %h/%h len %0d/%0d sum %h/%h",
                                     want.pidx, got.pidx, want.tag, got.tag,
                                     want.plen, got.plen, want.sum, got.sum);
                        end
                    end
                end
            end

            if (rx.valid && rx.ready)
                due_results.push_back(parse_byte(rx.rx_byte));

            // writes apply from the next byte on
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == sfd_pkg::REG_SYNC_FIRST)
                    sync_a = cfg.data;
                else if (cfg.index == sfd_pkg::REG_SYNC_SECOND)
                    sync_b = cfg.data;
            end

            errors  <= fail_cnt;
            pending <= due_results.size();
        end
    end

endmodule

@@ bench/tb_sync_frame_deframer_sum8.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_frame_deframer_sum8
// Drives byte streams of framed and broken traffic into the parser under
// several sync byte settings, with random gaps and receiver stalls; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sync_frame_deframer_sum8;

    localparam int ByteW          = sfd_pkg::ByteW;
    localparam int CfgIdxW        = sfd_pkg::CfgIdxW;
    localparam int HoldCycles     = 60;     // long receiver hold-off
    localparam int StallLimit     = 2000;   // cycles with no request moving
    localparam int FirstUnusedReg = int'(sfd_pkg::REG_SYNC_SECOND) + 1;

    logic clk;
    logic rst_n;

    sfd_in_if  rx_ch ();
    sfd_out_if res_ch ();
    sfd_cfg_if cfg_ch ();

    int errors;
    int pending;

    // stimulus controls, shared with the receiver process
    bit idle_on;
    bit hold_req;
    int holds_done;

    // sync bytes the stimulus builds frames with
    logic [ByteW-1:0] sync_first_now;
    logic [ByteW-1:0] sync_second_now;

    int bytes_sent;
    int good_frames;
    int bad_frames;
    int settings_run;
    int stall_cycles;

    sync_frame_deframer_sum8 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    sfd_scoreboard frame_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .res     (res_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off on request so
    // the result register backs up and the byte input stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        int span;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                span = $urandom_range(1, 15);
                repeat (span) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                span = $urandom_range(1, 12);
                repeat (span) @(posedge clk);
            end
        end
    end

    // Watchdog: any request moving on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= StallLimit)
        begin
            $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                     StallLimit, pending);
            $display("tb_sync_frame_deframer_sum8: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // One byte request. Ready is looked at on the falling edge, where all
    // inputs and block state for the coming rising edge have settled.
    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_ch.valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(negedge clk); while (!rx_ch.ready);
        @(posedge clk);
        bytes_sent++;
    endtask

    // Full frame: sync pair, total length, id, payload, checksum. The payload
    // count wraps like the block's: a total length under 5 means a long frame.
    task automatic send_frame(input logic [ByteW-1:0] len_byte, input logic [ByteW-1:0] id,
                              input bit good_sum);
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] n;
        logic [ByteW-1:0] b;
        logic [ByteW-1:0] flip;
        sum = sync_first_now + sync_second_now + len_byte + id;
        n   = len_byte - sfd_pkg::HdrTrlBytes;
        send_byte(sync_first_now);
        send_byte(sync_second_now);
        send_byte(len_byte);
        send_byte(id);
        for (int i = 0; i < int'(n); i++)
        begin
            b   = ByteW'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        if (good_sum)
        begin
            send_byte(sum);
            good_frames++;
        end
        else
        begin
            flip = ByteW'($urandom_range(1, 255));
            send_byte(sum ^ flip);
            bad_frames++;
        end
    endtask

    // Mostly short payloads, now and then a longer one.
    function automatic logic [ByteW-1:0] pick_length();
        int n;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(13, 40);
        else
            n = $urandom_range(0, 12);
        return ByteW'(n) + sfd_pkg::HdrTrlBytes;
    endfunction

    // Random traffic: well-formed frames with random content most of the
    // time, the rest is line noise and broken headers.
    task automatic run_traffic(input int count);
        int               stop_at;
        int               pick;
        int               k;
        logic [ByteW-1:0] b;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_frame(pick_length(), ByteW'($urandom_range(0, 255)),
                           $urandom_range(0, 3) != 0);
            end
            else if (pick < 82)
            begin
                // noise that never looks like a frame start
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    do b = ByteW'($urandom_range(0, 255)); while (b == sync_first_now);
                    send_byte(b);
                end
            end
            else if (pick < 94)
            begin
                // first sync then a wrong second byte; that byte may itself be
                // the first sync value, which must not restart the header
                send_byte(sync_first_now);
                if ($urandom_range(0, 1) == 0 && sync_first_now != sync_second_now)
                    b = sync_first_now;
                else
                    do b = ByteW'($urandom_range(0, 255)); while (b == sync_second_now);
                send_byte(b);
            end
            else
            begin
                k = $urandom_range(1, 3);
                repeat (k) send_byte(ByteW'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stop offering bytes and wait for every outstanding result.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_wait();
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
    endtask

    // Both sync registers, then a write to an index past the list, which the
    // block has to drop. Only called with the parser drained.
    task automatic write_syncs(input logic [ByteW-1:0] s1, input logic [ByteW-1:0] s2);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sfd_pkg::REG_SYNC_FIRST;
        cfg_ch.data  <= s1;
        cfg_wait();
        cfg_ch.index <= sfd_pkg::REG_SYNC_SECOND;
        cfg_ch.data  <= s2;
        cfg_wait();
        cfg_ch.index <= CfgIdxW'($urandom_range(FirstUnusedReg, 255));
        cfg_ch.data  <= ByteW'($urandom_range(0, 255));
        cfg_wait();
        cfg_ch.valid <= 1'b0;
        sync_first_now  = s1;
        sync_second_now = s2;
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        holds_done      = 0;
        bytes_sent      = 0;
        good_frames     = 0;
        bad_frames      = 0;
        settings_run    = 1;
        stall_cycles    = 0;
        sync_first_now  = sfd_pkg::SyncFirstRst;
        sync_second_now = sfd_pkg::SyncSecondRst;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset sync bytes.
        // byte extremes while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        // wrong second byte equal to the first sync, then a lone second sync:
        // neither may open a frame
        send_byte(sync_first_now);
        send_byte(sync_first_now);
        send_byte(sync_second_now);
        // empty payload, id 0, good checksum: must still close the frame
        send_frame(sfd_pkg::HdrTrlBytes, 8'h00, 1'b1);
        // two payload bytes, top id, corrupted checksum
        send_frame(sfd_pkg::HdrTrlBytes + 8'd2, 8'hFF, 1'b0);
        // single payload byte, good
        send_frame(sfd_pkg::HdrTrlBytes + 8'd1, 8'h80, 1'b1);

        run_traffic(80);

        // Extremes of the sync registers; the receiver takes a long break
        // right away while bytes keep coming.
        drain();
        write_syncs(8'h00, 8'hFF);
        hold_req = 1'b1;
        run_traffic(80);

        // Swapped extremes, with one frame whose total length is under 5 so
        // the payload count wraps to a long frame.
        drain();
        write_syncs(8'hFF, 8'h00);
        send_frame(ByteW'($urandom_range(0, 4)), ByteW'($urandom_range(0, 255)), 1'b1);
        run_traffic(30);

        // Random sync bytes (possibly equal); the final stretch runs flat out.
        drain();
        write_syncs(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
        run_traffic(30);
        idle_on = 1'b0;
        run_traffic(40);

        drain();

        $display("covered %0d bytes: %0d frames with good and %0d with bad checksums",
                 bytes_sent, good_frames, bad_frames);
        $display("over %0d sync settings, %0d long result hold-offs, %0d mismatches",
                 settings_run, holds_done, errors);
        if (errors == 0)
            $display("tb_sync_frame_deframer_sum8: done, clean");
        else
            $display("tb_sync_frame_deframer_sum8: done, errors");
        $finish;
    end

endmodule

@@ sync_frame_deframer_sum8.f @@
+incdir+src
src/sfd_pkg.sv
src/sfd_if.sv
src/sync_frame_deframer_sum8.sv
src/sfd_checker.sv
bench/sfd_checker.sv
bench/tb_sync_frame_deframer_sum8.sv
